@@ src/fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared constants, codes and state type of the cluster chain engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fcc_pkg;

    localparam int MAX_CLUSTERS = 4096;
    localparam int ROOT_CLUSTER = 1;
    localparam int ADDR_W       = $clog2(MAX_CLUSTERS);
    localparam int ENTRY_W      = 13;
    localparam int LEN_W        = 13;

    localparam logic [ENTRY_W-1:0] END_MARK   = 13'h1000;
    localparam logic [LEN_W-1:0]   MAX_LEN    = LEN_W'(MAX_CLUSTERS);
    localparam logic [LEN_W-1:0]   SCAN_START = LEN_W'(ROOT_CLUSTER + 1);

    localparam logic [2:0] FN_CREATE    = 3'd0;
    localparam logic [2:0] FN_REMOVE    = 3'd1;
    localparam logic [2:0] FN_ALLOCATE  = 3'd2;
    localparam logic [2:0] FN_PUT       = 3'd3;
    localparam logic [2:0] FN_GET       = 3'd4;
    localparam logic [2:0] FN_TRANSLATE = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic REG_CLUSTER_COUNT = 1'b0;
    localparam logic REG_DATA_FIRST    = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LINK_PREV,
        S_RM_PREV_RD,
        S_RM_PREV_EV,
        S_WALK_RD,
        S_WALK_EV,
        S_GET_RD,
        S_GET_EV,
        S_RESP
    } fsm_state_t;

endpackage

`default_nettype wire

@@ src/fat_cluster_chain_engine.sv @@
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine
// File allocation table in one 4096 x 13 synchronous RAM with chain operations.
// Create and allocate scan for free entries (one entry scanned per cycle);
//   allocate chains resume each scan above the last cluster found.
// Requests are taken one at a time; the RAM single read port sets the pace.
// Reset: registers return to 4096 and 1, then a clearing pass zeroes the
//   whole table while requests are stalled (config writes still taken).
// ----------------------------------------------------------------------------
`default_nettype none

module fat_cluster_chain_engine
    import fcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         func,
    input  wire logic [ADDR_W-1:0]  cluster,
    input  wire logic [ADDR_W-1:0]  prev_cluster,
    input  wire logic [ADDR_W-1:0]  entry_value,
    input  wire logic               value_is_end,
    input  wire logic [LEN_W-1:0]   count,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [ADDR_W-1:0]       result_cluster,
    output logic                    result_is_end,
    output logic [16:0]             sector_number,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // table RAM
    logic [ENTRY_W-1:0] mem [MAX_CLUSTERS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [ENTRY_W-1:0] mem_wd;
    logic [ADDR_W-1:0]  mem_ra;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // configuration registers
    logic [LEN_W-1:0] cluster_count_reg;
    logic [15:0]      data_first_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= MAX_LEN;
            data_first_reg    <= 16'd1;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_CLUSTER_COUNT)
            begin
                cluster_count_reg <= pwdata[LEN_W-1:0];
            end
            else
            begin
                data_first_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_CLUSTER_COUNT)
        begin
            prdata = {{(32-LEN_W){1'b0}}, cluster_count_reg};
        end
        else
        begin
            prdata = {16'd0, data_first_reg};
        end
    end

    logic [LEN_W-1:0] len;
    assign len = (cluster_count_reg > MAX_LEN) ? MAX_LEN : cluster_count_reg;

    // control and work registers
    fsm_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [2:0]         op_reg, op_next;
    logic [ADDR_W-1:0]  c_reg, c_next;
    logic [ADDR_W-1:0]  p_reg, p_next;
    logic [LEN_W-1:0]   need_reg, need_next;
    logic [LEN_W-1:0]   made_reg, made_next;
    logic [ADDR_W-1:0]  first_reg, first_next;
    logic [ADDR_W-1:0]  link_reg, link_next;
    logic [ADDR_W-1:0]  walk_reg, walk_next;
    logic               fail_reg, fail_next;
    logic [LEN_W-1:0]   scan_reg, scan_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [ADDR_W-1:0]  chk_addr_reg, chk_addr_next;

    logic [1:0]         res_st_reg, res_st_next;
    logic [ADDR_W-1:0]  res_rc_reg, res_rc_next;
    logic               res_re_reg, res_re_next;
    logic [16:0]        res_sec_reg, res_sec_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_st_reg, out_st_next;
    logic [ADDR_W-1:0]  out_rc_reg, out_rc_next;
    logic               out_re_reg, out_re_next;
    logic [16:0]        out_sec_reg, out_sec_next;

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign result_cluster = out_rc_reg;
    assign result_is_end  = out_re_reg;
    assign sector_number  = out_sec_reg;

    logic               accept;
    logic               c_ok;
    logic [ENTRY_W-1:0] put_val;
    logic               put_ok;
    logic               scan_issue;
    logic               rd_is_end;
    logic               rd_link_ok;

    assign accept    = in_valid && !in_stall;
    assign c_ok      = (cluster != '0) && ({1'b0, cluster} < len);
    assign put_val   = value_is_end ? END_MARK : {1'b0, entry_value};
    assign put_ok    = (put_val == END_MARK) || ((put_val != '0) && (put_val < len));
    assign scan_issue = (scan_reg < len);
    assign rd_is_end  = (rd_data_reg == END_MARK);
    assign rd_link_ok = rd_is_end || ((rd_data_reg != '0) && (rd_data_reg < len));

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        c_next         = c_reg;
        p_next         = p_reg;
        need_next      = need_reg;
        made_next      = made_reg;
        first_next     = first_reg;
        link_next      = link_reg;
        walk_next      = walk_reg;
        fail_next      = fail_reg;
        scan_next      = scan_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        res_st_next    = res_st_reg;
        res_rc_next    = res_rc_reg;
        res_re_next    = res_re_reg;
        res_sec_next   = res_sec_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = func;
                    c_next       = cluster;
                    p_next       = prev_cluster;
                    need_next    = (count == '0) ? LEN_W'(1) : count;
                    made_next    = '0;
                    link_next    = '0;
                    fail_next    = 1'b0;
                    scan_next    = SCAN_START;
                    res_st_next  = ST_BAD;
                    res_rc_next  = '0;
                    res_re_next  = 1'b0;
                    res_sec_next = '0;
                    state_next   = S_RESP;
                    unique case (func)
                        FN_CREATE:
                        begin
                            if ({1'b0, cluster} < len)
                            begin
                                link_next  = cluster;
                                state_next = S_SCAN;
                            end
                        end
                        FN_ALLOCATE:
                        begin
                            // an empty table rejects the chain start as a bad argument
                            if (len != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FN_REMOVE:
                        begin
                            walk_next = cluster;
                            if (c_ok && ({1'b0, prev_cluster} < len))
                            begin
                                state_next = (prev_cluster != '0) ? S_RM_PREV_RD
                                                                  : S_WALK_RD;
                            end
                        end
                        FN_PUT:
                        begin
                            if (c_ok && put_ok)
                            begin
                                mem_we      = 1'b1;
                                mem_wa      = cluster;
                                mem_wd      = put_val;
                                res_st_next = ST_OK;
                            end
                        end
                        FN_GET:
                        begin
                            if (c_ok)
                            begin
                                state_next = S_GET_RD;
                            end
                        end
                        FN_TRANSLATE:
                        begin
                            if (c_ok)
                            begin
                                res_st_next  = ST_OK;
                                res_sec_next = {1'b0, data_first_reg}
                                             + {5'd0, cluster} - 17'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // read one entry per cycle, test the one read last cycle
                mem_ra = scan_reg[ADDR_W-1:0];
                if (chk_valid_reg && (rd_data_reg == '0))
                begin
                    mem_we    = 1'b1;
                    mem_wa    = chk_addr_reg;
                    mem_wd    = END_MARK;
                    walk_next = chk_addr_reg;
                    if (made_reg == '0)
                    begin
                        first_next = chk_addr_reg;
                    end
                    state_next = S_LINK_PREV;
                end
                else if (scan_issue)
                begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_reg[ADDR_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                else if (!chk_valid_reg)
                begin
                    res_st_next = ST_FULL;
                    res_rc_next = '0;
                    if ((op_reg == FN_ALLOCATE) && (made_reg != '0))
                    begin
                        // give the partial chain back
                        fail_next  = 1'b1;
                        walk_next  = first_reg;
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_LINK_PREV:
            begin
                if (link_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = link_reg;
                    mem_wd = {1'b0, walk_reg};
                end
                if (op_reg == FN_CREATE)
                begin
                    res_st_next = ST_OK;
                    res_rc_next = walk_reg;
                    state_next  = S_RESP;
                end
                else
                begin
                    made_next = made_reg + 1'b1;
                    if ((made_reg + 1'b1) >= need_reg)
                    begin
                        res_st_next = ST_OK;
                        res_rc_next = first_reg;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        // everything below the last find is taken
                        link_next  = walk_reg;
                        scan_next  = {1'b0, walk_reg} + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_RM_PREV_RD:
            begin
                mem_ra     = p_reg;
                state_next = S_RM_PREV_EV;
            end

            S_RM_PREV_EV:
            begin
                if (rd_data_reg != {1'b0, c_reg})
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wa     = p_reg;
                    mem_wd     = END_MARK;
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                mem_ra     = walk_reg;
                state_next = S_WALK_EV;
            end

            S_WALK_EV:
            begin
                if (rd_is_end)
                begin
                    mem_we      = 1'b1;
                    mem_wa      = walk_reg;
                    res_st_next = fail_reg ? ST_FULL : ST_OK;
                    state_next  = S_RESP;
                end
                else if ((rd_data_reg == '0) || (rd_data_reg >= len))
                begin
                    // broken link: stop, keep what was freed
                    res_st_next = fail_reg ? ST_FULL : ST_BAD;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wa     = walk_reg;
                    walk_next  = rd_data_reg[ADDR_W-1:0];
                    state_next = S_WALK_RD;
                end
            end

            S_GET_RD:
            begin
                mem_ra     = c_reg;
                state_next = S_GET_EV;
            end

            S_GET_EV:
            begin
                if (rd_link_ok)
                begin
                    res_st_next = ST_OK;
                    res_re_next = rd_is_end;
                    res_rc_next = rd_is_end ? '0 : rd_data_reg[ADDR_W-1:0];
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_st_next    = out_st_reg;
        out_rc_next    = out_rc_reg;
        out_re_next    = out_re_reg;
        out_sec_next   = out_sec_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_RESP) && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            out_st_next    = res_st_reg;
            out_rc_next    = res_rc_reg;
            out_re_next    = res_re_reg;
            out_sec_next   = res_sec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        c_reg        <= c_next;
        p_reg        <= p_next;
        need_reg     <= need_next;
        made_reg     <= made_next;
        first_reg    <= first_next;
        link_reg     <= link_next;
        walk_reg     <= walk_next;
        fail_reg     <= fail_next;
        scan_reg     <= scan_next;
        chk_addr_reg <= chk_addr_next;
        res_st_reg   <= res_st_next;
        res_rc_reg   <= res_rc_next;
        res_re_reg   <= res_re_next;
        res_sec_reg  <= res_sec_next;
        out_st_reg   <= out_st_next;
        out_rc_reg   <= out_rc_next;
        out_re_reg   <= out_re_next;
        out_sec_reg  <= out_sec_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/fat_cluster_chain_engine_test.sv @@
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_test
// Checks the cluster chain engine against an in-bench model of the table.
// Directed table first, then random chain traffic over several register
// settings with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_test;
    import fcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  func;
        logic [11:0] cluster;
        logic [11:0] prev;
        logic [11:0] ev;
        logic        is_end;
        logic [12:0] count;
    } fat_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [11:0] rcluster;
        logic        rend;
        logic [16:0] sector;
    } fat_res_t;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 340;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = '0;
    logic [11:0] cluster = '0;
    logic [11:0] prev_cluster = '0;
    logic [11:0] entry_value = '0;
    logic        value_is_end = 1'b0;
    logic [12:0] count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [11:0] result_cluster;
    logic        result_is_end;
    logic [16:0] sector_number;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fat_cluster_chain_engine u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .cluster(cluster), .prev_cluster(prev_cluster),
        .entry_value(entry_value), .value_is_end(value_is_end), .count(count),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_cluster(result_cluster),
        .result_is_end(result_is_end), .sector_number(sector_number),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    // table model and registers
    logic [12:0] fat_tab [0:MAX_CLUSTERS-1];
    int unsigned clus_cnt = 4096;
    int unsigned first_sector = 1;

    fat_res_t expected_q [$];
    int mismatches = 0;
    int snd_pct = 0;
    int rcv_pct = 0;
    bit pressure_go = 1'b0;
    int idle_cycles = 0;

    function automatic int unsigned tab_len();
        return (clus_cnt > MAX_CLUSTERS) ? MAX_CLUSTERS : clus_cnt;
    endfunction

    function automatic bit link_ok(int unsigned v, int unsigned len);
        return (v == END_MARK) || (v != 0 && v < len);
    endfunction

    task automatic pred_new_link(input int unsigned c, output logic [1:0] st,
                                 output int unsigned made);
        int unsigned len;
        len = tab_len();
        made = 0;
        st = ST_FULL;
        if (c >= len) begin
            st = ST_BAD;
            return;
        end
        for (int unsigned n = ROOT_CLUSTER + 1; n < len; n++) begin
            if (fat_tab[n] == 0) begin
                fat_tab[n] = END_MARK;
                if (c != 0)
                    fat_tab[c] = 13'(n);
                made = n;
                st = ST_OK;
                return;
            end
        end
    endtask

    task automatic fat_remove(input int unsigned c, input int unsigned p,
                              output logic [1:0] st);
        int unsigned len, steps, nx;
        len = tab_len();
        steps = 0;
        st = ST_BAD;
        if (c == 0 || c >= len || p >= len)
            return;
        if (p != 0) begin
            if (fat_tab[p] != c)
                return;
            fat_tab[p] = END_MARK;
        end
        while (fat_tab[c] != END_MARK) begin
            nx = fat_tab[c];
            if (nx == 0 || nx >= len || steps > MAX_CLUSTERS)
                return;
            fat_tab[c] = 0;
            c = nx;
            steps++;
        end
        fat_tab[c] = 0;
        st = ST_OK;
    endtask

    task automatic fat_apply(input fat_req_t r, output fat_res_t o);
        int unsigned len, c, v, first, cur, nxt;
        logic [1:0] st;
        len = tab_len();
        c = r.cluster;
        o.status = ST_BAD;
        o.rcluster = '0;
        o.rend = 1'b0;
        o.sector = '0;
        case (r.func)
            FN_CREATE: begin
                pred_new_link(c, st, cur);
                o.status = st;
                o.rcluster = cur[11:0];
            end
            FN_REMOVE: begin
                fat_remove(c, r.prev, st);
                o.status = st;
            end
            FN_ALLOCATE: begin
                pred_new_link(0, st, first);
                if (st == ST_OK) begin
                    cur = first;
                    for (int unsigned i = 1; i < r.count; i++) begin
                        pred_new_link(cur, st, nxt);
                        cur = nxt;
                        if (st != ST_OK)
                            break;
                    end
                    if (st != ST_OK) begin
                        fat_remove(first, 0, st);
                        o.status = ST_FULL;
                    end else begin
                        o.status = ST_OK;
                        o.rcluster = first[11:0];
                    end
                end else begin
                    o.status = st;
                end
            end
            FN_PUT: begin
                v = r.is_end ? END_MARK : r.ev;
                if (c != 0 && c < len && link_ok(v, len)) begin
                    fat_tab[c] = 13'(v);
                    o.status = ST_OK;
                end
            end
            FN_GET: begin
                if (c != 0 && c < len) begin
                    v = fat_tab[c];
                    if (link_ok(v, len)) begin
                        o.status = ST_OK;
                        if (v == END_MARK)
                            o.rend = 1'b1;
                        else
                            o.rcluster = v[11:0];
                    end
                end
            end
            FN_TRANSLATE: begin
                if (c != 0 && c < len) begin
                    o.status = ST_OK;
                    o.sector = 17'(first_sector + c - 1);
                end
            end
            default: ;
        endcase
    endtask

    // caller stands at a falling edge and returns at one
    task automatic send_request(input fat_req_t r, input bit typed, input fat_res_t want);
        fat_res_t got;
        while ($urandom_range(99) < snd_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        func = r.func;
        cluster = r.cluster;
        prev_cluster = r.prev;
        entry_value = r.ev;
        value_is_end = r.is_end;
        count = r.count;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        fat_apply(r, got);
        expected_q.push_back(typed ? want : got);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] d);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = d;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == REG_CLUSTER_COUNT)
            clus_cnt = d[12:0];
        else
            first_sector = d[15:0];
    endtask

    function automatic int unsigned pick_cluster(int unsigned len);
        return $urandom_range(len - 1, 1);
    endfunction

    // mostly chain-shaped traffic drawn from the current table, some noise
    task automatic make_request(output fat_req_t r);
        int unsigned len, c, k;
        len = tab_len();
        r.func = 3'($urandom_range(5));
        r.cluster = 12'(pick_cluster(len));
        r.prev = '0;
        r.ev = 12'(pick_cluster(len));
        r.is_end = 1'($urandom_range(1));
        r.count = 13'($urandom_range(6));
        if ($urandom_range(99) < 15) begin
            r.func = 3'($urandom);
            r.cluster = 12'($urandom);
            r.prev = 12'($urandom);
            r.ev = 12'($urandom);
            r.is_end = 1'($urandom);
            r.count = (len <= 100) ? 13'($urandom) : 13'($urandom_range(40));
            return;
        end
        // land on a used entry when one turns up
        for (k = 0; k < 8; k++) begin
            c = pick_cluster(len);
            if (fat_tab[c] != 0) begin
                r.cluster = 12'(c);
                break;
            end
        end
        case (r.func)
            FN_CREATE: begin
                if ($urandom_range(3) == 0)
                    r.cluster = '0;
                else if (fat_tab[r.cluster] != END_MARK && $urandom_range(1))
                    r.cluster = '0;
            end
            FN_REMOVE: begin
                for (int unsigned n = 1; n < len; n++)
                    if (fat_tab[n] == r.cluster) begin
                        r.prev = 12'(n);
                        break;
                    end
                if ($urandom_range(9) == 0)
                    r.prev = 12'(pick_cluster(len));
            end
            default: ;
        endcase
    endtask

    // result channel stall, with one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (pressure_go && !held) begin
                held = 1'b1;
                out_stall = 1'b1;
                repeat (400) @(negedge clk);
            end
            out_stall = ($urandom_range(99) < rcv_pct);
        end
    end

    always @(posedge clk) begin
        fat_res_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d cluster %0d end %0d sector %0d",
                             status, result_cluster, result_is_end, sector_number);
            end else begin
                e = expected_q.pop_front();
                if (status !== e.status || result_cluster !== e.rcluster ||
                    result_is_end !== e.rend || sector_number !== e.sector) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 e.status, e.rcluster, e.rend, e.sector, status,
                                 result_cluster, result_is_end, sector_number);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_row(input logic [2:0] f, input int c, input int p, input int ev,
                           input bit e, input int cnt, input bit typed, input logic [1:0] st,
                           input int rc, input bit re, input int sec);
        fat_req_t r;
        fat_res_t w;
        r = '{f, 12'(c), 12'(p), 12'(ev), e, 13'(cnt)};
        w = '{st, 12'(rc), re, 17'(sec)};
        send_request(r, typed, w);
    endtask

    task automatic drain();
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    initial begin
        fat_req_t r;
        fat_res_t none;
        int unsigned cfg_cc [6];
        int unsigned cfg_ds [6];
        none = '{ST_OK, 12'd0, 1'b0, 17'd0};
        cfg_cc = '{4096, 16, 2, 40, 8191, 100};
        cfg_ds = '{1, 65535, 300, 1234, 40000, 0};
        cfg_ds[5] = $urandom_range(65535, 1);
        for (int i = 0; i < MAX_CLUSTERS; i++)
            fat_tab[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset registers
        add_row(FN_TRANSLATE, 1, 0, 1, 0, 0, 1, ST_OK, 0, 0, 1);
        add_row(FN_TRANSLATE, 4095, 0, 1, 0, 0, 1, ST_OK, 0, 0, 4095);
        add_row(FN_TRANSLATE, 0, 0, 1, 0, 0, 1, ST_BAD, 0, 0, 0);
        add_row(FN_GET, 5, 0, 1, 0, 0, 1, ST_BAD, 0, 0, 0);
        add_row(3'd6, 5, 5, 5, 1, 5, 1, ST_BAD, 0, 0, 0);
        add_row(3'd7, 4095, 4095, 4095, 1, 8191, 1, ST_BAD, 0, 0, 0);
        add_row(FN_CREATE, 0, 0, 1, 0, 0, 1, ST_OK, 2, 0, 0);
        add_row(FN_CREATE, 2, 0, 1, 0, 0, 1, ST_OK, 3, 0, 0);
        add_row(FN_GET, 2, 0, 1, 0, 0, 1, ST_OK, 3, 0, 0);
        add_row(FN_GET, 3, 0, 1, 0, 0, 1, ST_OK, 0, 1, 0);
        add_row(FN_PUT, 0, 0, 1, 1, 0, 1, ST_BAD, 0, 0, 0);
        add_row(FN_PUT, 11, 0, 0, 0, 0, 1, ST_BAD, 0, 0, 0);
        add_row(FN_PUT, 4095, 0, 0, 1, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_PUT, 10, 0, 4095, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_CREATE, 4, 0, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_REMOVE, 4, 0, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_REMOVE, 3, 2, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_REMOVE, 2, 0, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_REMOVE, 0, 0, 1, 0, 0, 1, ST_BAD, 0, 0, 0);
        add_row(FN_REMOVE, 5, 7, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_ALLOCATE, 0, 0, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_ALLOCATE, 0, 0, 1, 0, 1, 0, ST_OK, 0, 0, 0);
        add_row(FN_ALLOCATE, 0, 0, 1, 0, 3, 0, ST_OK, 0, 0, 0);
        add_row(FN_CREATE, 4095, 0, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        add_row(FN_GET, 4095, 0, 1, 0, 0, 0, ST_OK, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_CLUSTER_COUNT, cfg_cc[ph]);
            reg_write(REG_DATA_FIRST, cfg_ds[ph]);
            case (ph % 3)
                0: begin snd_pct = 31; rcv_pct = 49; end
                1: begin snd_pct = 49; rcv_pct = 31; end
                default: begin snd_pct = 0; rcv_pct = 0; end
            endcase
            if (ph == 2)
                pressure_go = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                make_request(r);
                send_request(r, 1'b0, none);
            end
            drain();
        end

        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
